@@ sv/mkoc_pkg.sv @@
package mkoc_pkg;

  // default build sizes
  localparam int NUM_WORDS_DEF   = 8;
  localparam int MAX_LEN_DEF     = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // operation codes
  localparam logic [2:0] OP_TEXT       = 3'd0;
  localparam logic [2:0] OP_WR_CHAR    = 3'd1;
  localparam logic [2:0] OP_SET_LEN    = 3'd2;
  localparam logic [2:0] OP_RD_COUNT   = 3'd3;
  localparam logic [2:0] OP_CLR_COUNTS = 3'd4;

  // keywords loaded at reset, right-justified in each entry
  localparam int DEF_WORDS = 8;
  localparam int DEF_SLOTS = 11;
  localparam logic [DEF_SLOTS*8-1:0] DEF_TEXT [DEF_WORDS] = '{
    "mundo", "modelo", "saber", "esporte",
    "financeiro", "empresa", "porta", "mercado"
  };
  localparam int DEF_LEN [DEF_WORDS] = '{5, 6, 5, 7, 10, 7, 5, 7};

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic [2:0] word_index;
    logic [4:0] char_position;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  match_mask;
    logic [31:0] count_value;
    logic [2:0]  word_index_echo;
  } out_item_t;

  // ascii upper case to lower case, other bytes unchanged
  function automatic logic [7:0] fold_char(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // reset character of keyword w at slot p
  function automatic logic [7:0] def_char(int w, int p);
    logic [7:0] c;
    c = '0;
    if (w >= 0 && w < DEF_WORDS) begin
      if (p >= 0 && p < DEF_LEN[w]) begin
        c = DEF_TEXT[w][(DEF_LEN[w] - 1 - p) * 8 +: 8];
      end
    end
    return c;
  endfunction

  // reset length of keyword w, cut to the slot count
  function automatic int def_len(int w, int max_len);
    int n;
    n = 0;
    if (w >= 0 && w < DEF_WORDS) begin
      n = (DEF_LEN[w] > max_len) ? max_len : DEF_LEN[w];
    end
    return n;
  endfunction

endpackage

@@ sv/mkoc_lane.sv @@
module mkoc_lane #(
  parameter int WORD_ID     = 0,
  parameter int MAX_LEN     = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   upd,
  input  mkoc_pkg::in_item_t     item,
  output logic                   hit,
  output logic [COUNT_WIDTH-1:0] count
);
  import mkoc_pkg::*;

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CUR_W = $clog2(MAX_LEN + 1);

  logic [7:0]             chars_r [MAX_LEN];
  logic [CUR_W-1:0]       len_r;
  logic [CUR_W-1:0]       cur_r;
  logic [COUNT_WIDTH-1:0] count_r;

  logic [CUR_W-1:0]       len_nxt;
  logic [CUR_W-1:0]       cur_nxt;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic                   wr_char;
  logic [IDX_W-1:0]       wr_slot;
  logic                   sel;
  logic [7:0]             t_byte;
  logic [7:0]             c_cur;
  logic [7:0]             c_first;
  logic [CUR_W-1:0]       step_cur;
  logic                   done;

  assign sel     = (int'(item.word_index) == WORD_ID);
  assign t_byte  = fold_char(item.data_byte);
  assign c_cur   = fold_char(chars_r[cur_r[IDX_W-1:0]]);
  assign c_first = fold_char(chars_r[0]);
  assign wr_slot = IDX_W'(item.char_position);

  // cursor step for a text byte
  always_comb begin
    if (cur_r < len_r && c_cur == t_byte) begin
      step_cur = cur_r + 1'b1;
    end else if (c_first == t_byte) begin
      step_cur = CUR_W'(1);
    end else begin
      step_cur = '0;
    end
  end

  assign done = (item.op == OP_TEXT) && (len_r != '0) && (step_cur >= len_r);
  assign hit  = done;

  // next state per operation
  always_comb begin
    len_nxt   = len_r;
    cur_nxt   = cur_r;
    count_nxt = count_r;
    wr_char   = 1'b0;
    case (item.op)
      OP_TEXT: begin
        if (len_r != '0) begin
          cur_nxt = done ? '0 : step_cur;
          if (done && count_r != '1) begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      OP_WR_CHAR: begin
        if (sel && int'(item.char_position) < MAX_LEN) begin
          wr_char = 1'b1;
          cur_nxt = '0;
        end
      end
      OP_SET_LEN: begin
        if (sel) begin
          len_nxt = (int'(item.char_position) > MAX_LEN) ? CUR_W'(MAX_LEN)
                                                         : CUR_W'(item.char_position);
          cur_nxt = '0;
        end
      end
      OP_CLR_COUNTS: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // keyword storage, cursor and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < MAX_LEN; p++) begin
        chars_r[p] <= def_char(WORD_ID, p);
      end
      len_r   <= CUR_W'(def_len(WORD_ID, MAX_LEN));
      cur_r   <= '0;
      count_r <= '0;
    end else if (upd) begin
      if (wr_char) begin
        chars_r[wr_slot] <= item.data_byte;
      end
      len_r   <= len_nxt;
      cur_r   <= cur_nxt;
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

@@ sv/multi_keyword_occurrence_counter_top.sv @@
// an accepted item is held in the input register, and its result is loaded into the result register
// one item per cycle while the result register is not held by out_stall; each keyword has its own compare lane and
// all lanes step in parallel between the input register and the result register
// reset (synchronous, active low): default keywords and lengths reloaded,
// cursors and counts cleared, both pipeline registers emptied
module multi_keyword_occurrence_counter_top #(
  parameter int NUM_WORDS   = mkoc_pkg::NUM_WORDS_DEF,
  parameter int MAX_LEN     = mkoc_pkg::MAX_LEN_DEF,
  parameter int COUNT_WIDTH = mkoc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mkoc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mkoc_pkg::out_item_t out_item
);
  import mkoc_pkg::*;

  logic                   s1_valid_r;
  in_item_t               s1_item_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic                   s1_go;
  logic [NUM_WORDS-1:0]   hit;
  logic [COUNT_WIDTH-1:0] cnt [NUM_WORDS];
  logic [7:0]             mask;
  logic [63:0]            rd_cnt;
  logic [31:0]            rd_sat;
  out_item_t              res;

  // stage one moves on unless the result register is held
  assign s1_go    = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_go;

  // one lane per keyword
  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_lane
    mkoc_lane #(
      .WORD_ID     (w),
      .MAX_LEN     (MAX_LEN),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .upd   (s1_go),
      .item  (s1_item_r),
      .hit   (hit[w]),
      .count (cnt[w])
    );
  end

  // only the first eight keywords show in the mask
  for (genvar b = 0; b < 8; b++) begin : g_mask
    if (b < NUM_WORDS) begin : g_on
      assign mask[b] = hit[b];
    end else begin : g_off
      assign mask[b] = 1'b0;
    end
  end

  // count read select, saturated to the port width
  always_comb begin
    rd_cnt = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (int'(s1_item_r.word_index) == w) begin
        rd_cnt = 64'(cnt[w]);
      end
    end
    rd_sat = (rd_cnt > 64'h0000_0000_FFFF_FFFF) ? '1 : rd_cnt[31:0];
  end

  // result item
  always_comb begin
    res.match_mask      = (s1_item_r.op == OP_TEXT) ? mask : '0;
    res.count_value     = (s1_item_r.op == OP_RD_COUNT) ? rd_sat : '0;
    res.word_index_echo = s1_item_r.word_index;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
